// ===== hw/rtl/depth_buffer_to_point_cloud_core_macros.svh =====
// Assertion macros for the depth buffer unprojection core.
`ifndef DEPTH_BUFFER_TO_POINT_CLOUD_CORE_MACROS_SVH
`define DEPTH_BUFFER_TO_POINT_CLOUD_CORE_MACROS_SVH

// Property that holds at every rising clock edge outside reset.
`define DBPC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("dbpc check failed");

// Implication checked in the same cycle.
`define DBPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dbpc check failed");

`endif

// ===== hw/rtl/dbpc_pkg.sv =====
`timescale 1ns / 1ps
package dbpc_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int DEPTH_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [2:0] REG_FOCAL_U      = 3'd0;
  localparam logic [2:0] REG_FOCAL_V      = 3'd1;
  localparam logic [2:0] REG_NEAR_PLANE   = 3'd2;
  localparam logic [2:0] REG_FAR_PLANE    = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

  localparam logic [23:0] FOCAL_RST  = 24'd256;
  localparam logic [31:0] NEAR_RST   = 32'd65536;
  localparam logic [31:0] FAR_RST    = 32'd1310720;
  localparam logic [12:0] SIZE_RST   = 13'd1;

  typedef struct packed {
    logic [23:0] focal_u;
    logic [23:0] focal_v;
    logic [31:0] near_plane;
    logic [31:0] far_plane;
  } cam_cfg_t;

endpackage

// ===== hw/rtl/dbpc_fifo.sv =====
`timescale 1ns / 1ps
module dbpc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = dbpc_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;

  assign full  = (level == LW'(DEPTH));
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
    if (pop) begin
      rdata <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/dbpc_div.sv =====
`timescale 1ns / 1ps
module dbpc_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic          ovf,
  output logic [31:0]   quo
);
  localparam int CW = (NW > DW + 32) ? NW : DW + 32;

  logic [CW-1:0] rem, dsh;
  logic [4:0]    cnt;
  logic          run;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(dividend);
      dsh <= CW'(divisor) << 31;
      ovf <= (divisor == '0) || ((CW'(divisor) << 32) <= CW'(dividend));
      quo <= '0;
    end else if (run) begin
      if (dsh <= rem) begin
        rem <= rem - dsh;
        quo <= {quo[30:0], 1'b1};
      end else begin
        quo <= {quo[30:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/dbpc_front.sv =====
`timescale 1ns / 1ps
module dbpc_front #(
  parameter int MAX_WIDTH  = dbpc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dbpc_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dbpc_pkg::DEPTH_BITS_DEF,
  parameter int OW         = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DEPTH_BITS-1:0] depth_sample,
  input  logic                  frame_start,
  input  logic [12:0]           image_width,
  input  logic [12:0]           image_height,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [DEPTH_BITS-1:0] q_depth,
  output logic [OW-1:0]         q_du,
  output logic [OW-1:0]         q_dv,
  output logic                  q_fe
);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int WH = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0] column_count, column_count_next, w, c0, c1, c3;
  logic [WH-1:0] row_count, row_count_next, h, r0, r1, r2, r3;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_depth  = depth_sample;

  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == '0) begin
      h = WH'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = WH'(MAX_HEIGHT);
    end else begin
      h = WH'(image_height);
    end

    c0 = frame_start ? '0 : column_count;
    r0 = frame_start ? '0 : row_count;
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h) ? '0 : r1;

    q_du = OW'(c1) - OW'(w >> 1);
    q_dv = OW'(h) - OW'(r2) - OW'(h >> 1);
    q_fe = (c1 == w - 1'b1) && (r2 == h - 1'b1);

    c3 = c1 + 1'b1;
    r3 = r2 + 1'b1;
    if (c3 >= w) begin
      column_count_next = '0;
      row_count_next    = (r3 >= h) ? '0 : r3;
    end else begin
      column_count_next = c3;
      row_count_next    = r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end
endmodule

// ===== hw/rtl/dbpc_back.sv =====
`timescale 1ns / 1ps
module dbpc_back #(
  parameter int DEPTH_BITS = dbpc_pkg::DEPTH_BITS_DEF,
  parameter int OW         = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dbpc_pkg::cam_cfg_t    cfg,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [DEPTH_BITS-1:0] q_depth,
  input  logic [OW-1:0]         q_du,
  input  logic [OW-1:0]         q_dv,
  input  logic                  q_fe,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    point_x,
  output logic signed [31:0]    point_y,
  output logic [31:0]           point_z,
  output logic                  frame_end
);
  localparam int DB    = DEPTH_BITS;
  localparam int DA_W  = DB + 33;
  localparam int DN_W  = DB + 34;
  localparam int NUM_W = DB + 64;
  localparam int PW    = 32 + OW;
  localparam int LW    = PW + 8;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MNF  = 4'd1;
  localparam logic [3:0] S_MDA  = 4'd2;
  localparam logic [3:0] S_MDB  = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_ZST  = 4'd5;
  localparam logic [3:0] S_ZW   = 4'd6;
  localparam logic [3:0] S_MX   = 4'd7;
  localparam logic [3:0] S_MY   = 4'd8;
  localparam logic [3:0] S_LST  = 4'd9;
  localparam logic [3:0] S_LW   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]      st;
  logic [DB-1:0]   s_r;
  logic [OW-1:0]   du_r, dv_r, magx, magy;
  logic            fe_r;
  logic [63:0]     nf;
  logic [DA_W-1:0] dena;
  logic [DN_W-1:0] denb, den;
  logic [31:0]     z, xr, yr;
  logic [LW-1:0]   px, py;
  logic            z_done, z_ovf, x_done, x_ovf, y_done, y_ovf, lat_start, load_out;
  logic [31:0]     z_quo, x_quo, y_quo;

  function automatic logic [31:0] sat_lat(input logic zero, input logic ovf,
                                          input logic neg, input logic [31:0] q);
    logic [31:0] r;
    if (zero) begin
      r = '0;
    end else if (ovf || q[31]) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? (~q + 1'b1) : q;
    end
    return r;
  endfunction

  assign magx      = du_r[OW-1] ? (~du_r + 1'b1) : du_r;
  assign magy      = dv_r[OW-1] ? (~dv_r + 1'b1) : dv_r;
  assign q_pop     = (st == S_IDLE) && !q_empty;
  assign lat_start = (st == S_LST);
  assign load_out  = (st == S_OUT) && (!out_valid || !out_stall);

  dbpc_div #(.NW(NUM_W), .DW(DN_W)) u_zdiv (
    .clk(clk), .rst(rst), .start(st == S_ZST), .dividend({nf, DB'(0)}), .divisor(den),
    .done(z_done), .ovf(z_ovf), .quo(z_quo)
  );

  dbpc_div #(.NW(LW), .DW(24)) u_xdiv (
    .clk(clk), .rst(rst), .start(lat_start), .dividend(px), .divisor(cfg.focal_u),
    .done(x_done), .ovf(x_ovf), .quo(x_quo)
  );

  dbpc_div #(.NW(LW), .DW(24)) u_ydiv (
    .clk(clk), .rst(rst), .start(lat_start), .dividend(py), .divisor(cfg.focal_v),
    .done(y_done), .ovf(y_ovf), .quo(y_quo)
  );

  always_ff @(posedge clk) begin
    case (st)
      S_MNF: begin
        s_r  <= q_depth;
        du_r <= q_du;
        dv_r <= q_dv;
        fe_r <= q_fe;
        nf   <= 64'(cfg.near_plane) * 64'(cfg.far_plane);
      end
      S_MDA: dena <= DA_W'(cfg.far_plane) * (DA_W'(1) << DB) - DA_W'(cfg.far_plane)
                     * DA_W'(s_r);
      S_MDB: denb <= DN_W'(s_r) * DN_W'(cfg.near_plane);
      S_ADD: den  <= DN_W'(dena) + denb;
      S_ZW: begin
        if (z_done) begin
          z <= (den == '0) ? '0 : (z_ovf ? 32'hFFFF_FFFF : z_quo);
        end
      end
      S_MX: px <= {PW'(z) * PW'(magx), 8'd0};
      S_MY: py <= {PW'(z) * PW'(magy), 8'd0};
      S_LW: begin
        if (x_done) begin
          xr <= sat_lat(px == '0, x_ovf, du_r[OW-1], x_quo);
          yr <= sat_lat(py == '0, y_ovf, dv_r[OW-1], y_quo);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      point_x   <= xr;
      point_y   <= yr;
      point_z   <= z;
      frame_end <= fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
      case (st)
        S_IDLE:  st <= q_empty ? S_IDLE : S_MNF;
        S_MNF:   st <= S_MDA;
        S_MDA:   st <= S_MDB;
        S_MDB:   st <= S_ADD;
        S_ADD:   st <= S_ZST;
        S_ZST:   st <= S_ZW;
        S_ZW:    st <= z_done ? S_MX : S_ZW;
        S_MX:    st <= S_MY;
        S_MY:    st <= S_LST;
        S_LST:   st <= S_LW;
        S_LW:    st <= x_done ? S_OUT : S_LW;
        S_OUT:   st <= load_out ? S_IDLE : S_OUT;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/depth_buffer_to_point_cloud_core.sv =====
`timescale 1ns / 1ps
// Depth buffer to camera-frame point cloud, pinhole camera model.
// Input channel: one depth_sample per pixel in raster order, frame_start on the
//   first pixel of a frame; a beat moves on in_valid high and in_stall low.
// Output channel: point_x, point_y (signed Q16.16), point_z (Q16.16) and
//   frame_end; a beat moves on out_valid high and out_stall low.
// Config channel: cfg_index selects focal_u, focal_v, near_plane, far_plane,
//   image_width, image_height; written on cfg_valid with cfg_ready (always high).
//   Write only while no pixel is in flight.
// A front stage tracks column and row and queues four pixels ahead; the back
//   end works one pixel at a time, through the 32-step depth divider and the
//   32-step lateral dividers, each with its collect state, plus pop, setup,
//   products and output load.
// An accepted beat is queued, popped and taken through the back-end states before its result is valid.
// Reset clears the counters, the queue and out_valid, and loads the
//   default camera (focal 1.0, near 1.0, far 20.0, 1x1 image).
// While out_stall is high the result holds; the back end then stops and the
//   queue fills, after which in_stall rises.
module depth_buffer_to_point_cloud_core #(
  parameter int MAX_WIDTH  = dbpc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dbpc_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dbpc_pkg::DEPTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DEPTH_BITS-1:0] depth_sample,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    point_x,
  output logic signed [31:0]    point_y,
  output logic [31:0]           point_z,
  output logic                  frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int WH    = $clog2(MAX_HEIGHT + 1);
  localparam int OW    = ((WW > WH) ? WW : WH) + 1;
  localparam int EW    = DEPTH_BITS + 2 * OW + 1;
  localparam int QD    = dbpc_pkg::QUEUE_DEPTH;
  localparam int QLW   = $clog2(QD + 1);

  dbpc_pkg::cam_cfg_t    cfg;
  logic [12:0]           image_width, image_height;
  logic                  q_push, q_pop, q_full, q_empty, f_fe, b_fe;
  logic [QLW-1:0]        q_level;
  logic [DEPTH_BITS-1:0] f_depth, b_depth;
  logic [OW-1:0]         f_du, f_dv, b_du, b_dv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_u    <= dbpc_pkg::FOCAL_RST;
      cfg.focal_v    <= dbpc_pkg::FOCAL_RST;
      cfg.near_plane <= dbpc_pkg::NEAR_RST;
      cfg.far_plane  <= dbpc_pkg::FAR_RST;
      image_width    <= dbpc_pkg::SIZE_RST;
      image_height   <= dbpc_pkg::SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dbpc_pkg::REG_FOCAL_U:      cfg.focal_u    <= cfg_data[23:0];
        dbpc_pkg::REG_FOCAL_V:      cfg.focal_v    <= cfg_data[23:0];
        dbpc_pkg::REG_NEAR_PLANE:   cfg.near_plane <= cfg_data;
        dbpc_pkg::REG_FAR_PLANE:    cfg.far_plane  <= cfg_data;
        dbpc_pkg::REG_IMAGE_WIDTH:  image_width    <= cfg_data[12:0];
        dbpc_pkg::REG_IMAGE_HEIGHT: image_height   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  dbpc_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .DEPTH_BITS(DEPTH_BITS), .OW(OW)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .depth_sample(depth_sample), .frame_start(frame_start),
    .image_width(image_width), .image_height(image_height),
    .q_full(q_full), .q_push(q_push), .q_depth(f_depth), .q_du(f_du), .q_dv(f_dv),
    .q_fe(f_fe)
  );

  dbpc_fifo #(.W(EW), .DEPTH(QD)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata({f_depth, f_du, f_dv, f_fe}),
    .full(q_full), .pop(q_pop), .rdata({b_depth, b_du, b_dv, b_fe}),
    .empty(q_empty), .level(q_level)
  );

  dbpc_back #(.DEPTH_BITS(DEPTH_BITS), .OW(OW)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_pop(q_pop),
    .q_depth(b_depth), .q_du(b_du), .q_dv(b_dv), .q_fe(b_fe),
    .out_valid(out_valid), .out_stall(out_stall), .point_x(point_x),
    .point_y(point_y), .point_z(point_z), .frame_end(frame_end)
  );

`include "depth_buffer_to_point_cloud_core_macros.svh"

  `DBPC_ASSERT(a_level_bound, q_level <= QLW'(QD))
  `DBPC_ASSERT_IMP(a_pop_nonempty, q_pop, q_level != '0)
  `DBPC_ASSERT_IMP(a_push_not_full, q_push, q_level != QLW'(QD))

endmodule

// ===== tb/tb_depth_buffer_to_point_cloud_core.sv =====
`timescale 1ns / 1ps
module tb_depth_buffer_to_point_cloud_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SIZE_MAX    = 4096;
  localparam int HOLD_LEN    = 800;
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        z;
    logic               fend;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [23:0] depth_sample = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] point_x, point_y;
  logic [31:0] point_z;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  depth_buffer_to_point_cloud_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .depth_sample(depth_sample), .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // camera shadow and raster position
  logic [23:0] cam_focal_u = dbpc_pkg::FOCAL_RST, cam_focal_v = dbpc_pkg::FOCAL_RST;
  logic [31:0] cam_near = dbpc_pkg::NEAR_RST, cam_far = dbpc_pkg::FAR_RST;
  logic [12:0] cam_width = dbpc_pkg::SIZE_RST, cam_height = dbpc_pkg::SIZE_RST;
  int unsigned col_pos = 0, row_pos = 0;

  point_t expected_points[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  int stall_pct = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] eye_depth(logic [23:0] s);
    logic [127:0] num, den, q;
    num = ({96'd0, cam_near} * {96'd0, cam_far}) << 24;
    den = {96'd0, cam_far} * (128'd1 << 24) - {96'd0, cam_far} * {104'd0, s}
          + {104'd0, s} * {96'd0, cam_near};
    if (den == 0) return 32'd0;
    if ((den << 32) <= num) return 32'hFFFFFFFF;
    q = num / den;
    return q[31:0];
  endfunction

  function automatic logic [31:0] offset_coord(logic [31:0] z, int off, logic [23:0] focal);
    logic [63:0] mag, q;
    mag = (off < 0) ? 64'(-off) : 64'(off);
    if (mag == 0 || z == 0) return 32'd0;
    if (focal == 0) q = '1;
    else q = ({32'd0, z} * mag * 64'd256) / {40'd0, focal};
    if (off < 0) return (q >= 64'h80000000) ? 32'h80000000 : 32'(-q);
    return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
  endfunction

  function automatic point_t unproject_pixel(logic [23:0] s, logic fs);
    point_t p;
    int unsigned w, h;
    int du, dv;
    w = (cam_width == 0) ? 1 : (cam_width > SIZE_MAX ? SIZE_MAX : cam_width);
    h = (cam_height == 0) ? 1 : (cam_height > SIZE_MAX ? SIZE_MAX : cam_height);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    p.z = eye_depth(s);
    du = int'(col_pos) - int'(w / 2);
    dv = int'(h - row_pos) - int'(h / 2);
    p.x = offset_coord(p.z, du, cam_focal_u);
    p.y = offset_coord(p.z, dv, cam_focal_v);
    p.fend = (col_pos == w - 1 && row_pos == h - 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return p;
  endfunction

  task automatic send_pixel(input logic [23:0] d, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    depth_sample <= d;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(unproject_pixel(d, fs));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dbpc_pkg::REG_FOCAL_U:      cam_focal_u = val[23:0];
      dbpc_pkg::REG_FOCAL_V:      cam_focal_v = val[23:0];
      dbpc_pkg::REG_NEAR_PLANE:   cam_near = val;
      dbpc_pkg::REG_FAR_PLANE:    cam_far = val;
      dbpc_pkg::REG_IMAGE_WIDTH:  cam_width = val[12:0];
      dbpc_pkg::REG_IMAGE_HEIGHT: cam_height = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_camera(input logic [23:0] fu, input logic [23:0] fv,
                            input logic [31:0] nr, input logic [31:0] fr,
                            input logic [12:0] w, input logic [12:0] h);
    write_reg(dbpc_pkg::REG_FOCAL_U, {8'd0, fu});
    write_reg(dbpc_pkg::REG_FOCAL_V, {8'd0, fv});
    write_reg(dbpc_pkg::REG_NEAR_PLANE, nr);
    write_reg(dbpc_pkg::REG_FAR_PLANE, fr);
    write_reg(dbpc_pkg::REG_IMAGE_WIDTH, {19'd0, w});
    write_reg(dbpc_pkg::REG_IMAGE_HEIGHT, {19'd0, h});
  endtask

  // output checker
  always @(posedge clk) begin
    point_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point beat");
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (point_x !== e.x) begin
            $error("point_x expected %0d got %0d", e.x, point_x);
            errors++;
          end
          if (point_y !== e.y) begin
            $error("point_y expected %0d got %0d", e.y, point_y);
            errors++;
          end
          if (point_z !== e.z) begin
            $error("point_z expected %0h got %0h", e.z, point_z);
            errors++;
          end
          if (frame_end !== e.fend) begin
            $error("frame_end expected %0b got %0b", e.fend, frame_end);
            errors++;
          end
        end
      end
    end
  end

  // receiver stall pattern and long hold
  always @(posedge clk) begin
    if (!rst) begin
      if (cycles % 256 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      if (hold_req && hold_cycles < HOLD_LEN) begin
        hold_cycles++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic test_reset_camera;
    send_pixel(24'd0, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h800000, 1'b1);
  endtask

  task automatic test_depth_extremes;
    set_camera(24'd256, 24'd512, 32'h0000_8000, 32'h0064_0000, 13'd4, 13'd3);
    send_pixel(24'd0, 1'b1);
    send_pixel(24'd1, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h555555, 1'b0);
    send_pixel(24'hAAAAAA, 1'b0);
  endtask

  task automatic test_zero_focal;
    write_reg(dbpc_pkg::REG_FOCAL_U, 32'd0);
    write_reg(dbpc_pkg::REG_FOCAL_V, 32'd0);
    send_pixel(24'h123456, 1'b1);
    send_pixel(24'h654321, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
  endtask

  task automatic test_saturation;
    set_camera(24'd1, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 13'd3, 13'd2);
    send_pixel(24'd0, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    write_reg(dbpc_pkg::REG_NEAR_PLANE, 32'd1);
    send_pixel(24'hFFFFFF, 1'b0);
  endtask

  task automatic test_zero_far;
    write_reg(dbpc_pkg::REG_FAR_PLANE, 32'd0);
    send_pixel(24'd0, 1'b1);
    write_reg(dbpc_pkg::REG_NEAR_PLANE, 32'd0);
    send_pixel(24'h3C3C3C, 1'b0);
  endtask

  task automatic test_size_limits;
    set_camera(24'd256, 24'd256, dbpc_pkg::NEAR_RST, dbpc_pkg::FAR_RST, 13'd0, 13'h1FFF);
    send_pixel(24'h400000, 1'b1);
    write_reg(dbpc_pkg::REG_IMAGE_WIDTH, 32'hFFFF_FFFF);
    write_reg(dbpc_pkg::REG_IMAGE_HEIGHT, 32'd0);
    send_pixel(24'h7FFFFF, 1'b1);
    // shrink mid frame: stale column and row
    write_reg(dbpc_pkg::REG_IMAGE_WIDTH, 32'd6);
    write_reg(dbpc_pkg::REG_IMAGE_HEIGHT, 32'd5);
    repeat (3) send_pixel(24'($urandom), 1'b0);
    write_reg(dbpc_pkg::REG_IMAGE_WIDTH, 32'd2);
    write_reg(dbpc_pkg::REG_IMAGE_HEIGHT, 32'd1);
    send_pixel(24'h00FF00, 1'b0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(REG_SPARE + 3'd1, 32'h1234_5678);
    send_pixel(24'hFF00FF, 1'b0);
  endtask

  task automatic test_backpressure;
    set_camera(24'd300, 24'd300, dbpc_pkg::NEAR_RST, dbpc_pkg::FAR_RST, 13'd3, 13'd3);
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_pixel(24'($urandom), i == 0);
  endtask

  function automatic logic [23:0] pick_depth;
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_random_frames;
    int sent, w, h, n;
    logic [31:0] nr, fr;
    sent = 0;
    while (sent < 600) begin
      nr = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000);
      fr = ($urandom_range(0, 7) == 0) ? $urandom : nr + $urandom_range(0, 32'h0100_0000);
      w = ($urandom_range(0, 9) == 0) ? SIZE_MAX : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? SIZE_MAX : $urandom_range(1, 6);
      set_camera(($urandom_range(0, 3) == 0) ? 24'($urandom)
                                             : 24'($urandom_range(1, 2048)),
                 ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                             : 24'($urandom_range(1, 2048)),
                 nr, fr, w[12:0], h[12:0]);
      n = (w * h > 40) ? 20 : w * h * $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel(pick_depth(), 1'($urandom_range(0, 1)));
        else
          send_pixel(pick_depth(), (i % (w * h)) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_camera();
    test_depth_extremes();
    test_zero_focal();
    test_saturation();
    test_zero_far();
    test_size_limits();
    test_backpressure();
    test_random_frames();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_points.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
